// ===== hw/rtl/stp_pkg.sv =====
// ============================================================================
// stp_pkg - spanning-tree port state shared definitions
// Field widths, register indexes, reset values and the beat/config structs.
// ============================================================================
`default_nettype none

package stp_pkg;

  localparam int ADDR_W     = 16;
  localparam int PORT_W     = 3;
  localparam int MASK_W     = 8;
  localparam int CNT_W      = 4;
  localparam int TIMER_W    = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_PORTS_DEFAULT = 8;

  localparam logic [ADDR_W-1:0] UNKNOWN_ADDR = 16'hFFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_COUNT        = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HELLO_INTERVAL    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REELECT_INTERVAL  = 8'd3;

  // register reset values
  localparam logic [ADDR_W-1:0]  OWN_ADDRESS_RST         = 16'd0;
  localparam logic [CNT_W-1:0]   PORT_COUNT_RST          = 4'd8;
  localparam logic [TIMER_W-1:0] HELLO_INTERVAL_RST      = 32'd1000;
  localparam logic [TIMER_W-1:0] REELECTION_INTERVAL_RST = 32'd3000;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_HELLO = 1'b1
  } action_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  own_address;
    logic [CNT_W-1:0]   port_count;
    logic [TIMER_W-1:0] hello_interval;
    logic [TIMER_W-1:0] reelection_interval;
  } cfg_t;

  // start-up load of root/parent when own_address is written
  typedef struct packed {
    logic              load;
    logic [ADDR_W-1:0] addr;
  } own_load_t;

  typedef struct packed {
    action_t           action;
    logic [PORT_W-1:0] in_port;
    logic [ADDR_W-1:0] hello_root;
    logic [ADDR_W-1:0] hello_path;
    logic [ADDR_W-1:0] hello_sender;
  } item_t;

  typedef struct packed {
    logic [MASK_W-1:0] send_mask;
    logic [ADDR_W-1:0] root_now;
    logic [ADDR_W-1:0] path_now;
    logic [ADDR_W-1:0] parent_now;
    logic [MASK_W-1:0] blocked_mask;
    logic              converged;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stp_if.sv =====
// ============================================================================
// stp_if - channel interfaces
// Item, result and configuration channels, each a valid/ready pair plus payload.
// ============================================================================
`default_nettype none

interface stp_item_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [stp_pkg::PORT_W-1:0]    in_port;
  logic [stp_pkg::ADDR_W-1:0]    hello_root;
  logic [stp_pkg::ADDR_W-1:0]    hello_path;
  logic [stp_pkg::ADDR_W-1:0]    hello_sender;

  modport source (output valid, action, in_port, hello_root, hello_path, hello_sender,
                  input ready);
  modport sink   (input valid, action, in_port, hello_root, hello_path, hello_sender,
                  output ready);
endinterface

interface stp_result_if;
  logic                          valid;
  logic                          ready;
  logic [stp_pkg::MASK_W-1:0]    send_mask;
  logic [stp_pkg::ADDR_W-1:0]    root_now;
  logic [stp_pkg::ADDR_W-1:0]    path_now;
  logic [stp_pkg::ADDR_W-1:0]    parent_now;
  logic [stp_pkg::MASK_W-1:0]    blocked_mask;
  logic                          converged;

  modport source (output valid, send_mask, root_now, path_now, parent_now, blocked_mask,
                  converged, input ready);
  modport sink   (input valid, send_mask, root_now, path_now, parent_now, blocked_mask,
                  converged, output ready);
endinterface

interface stp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [stp_pkg::CFG_IDX_W-1:0]   index;
  logic [stp_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stp_cfg.sv =====
// ============================================================================
// stp_cfg - configuration register file
// Four registers written by index; an own_address write also requests a
// start-up load of root and parent in the engine.
// ============================================================================
`default_nettype none

module stp_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  stp_cfg_if.sink            cfg,
  output stp_pkg::cfg_t      regs,
  output stp_pkg::own_load_t own_load
);

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;

  assign own_load.load = wr && (cfg.index == stp_pkg::REG_OWN_ADDRESS);
  assign own_load.addr = cfg.data[stp_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.own_address         <= stp_pkg::OWN_ADDRESS_RST;
      regs.port_count          <= stp_pkg::PORT_COUNT_RST;
      regs.hello_interval      <= stp_pkg::HELLO_INTERVAL_RST;
      regs.reelection_interval <= stp_pkg::REELECTION_INTERVAL_RST;
    end else if (wr) begin
      case (cfg.index)
        stp_pkg::REG_OWN_ADDRESS:
          regs.own_address <= cfg.data[stp_pkg::ADDR_W-1:0];
        stp_pkg::REG_PORT_COUNT:
          regs.port_count <= cfg.data[stp_pkg::CNT_W-1:0];
        stp_pkg::REG_HELLO_INTERVAL:
          regs.hello_interval <= cfg.data[stp_pkg::TIMER_W-1:0];
        stp_pkg::REG_REELECT_INTERVAL:
          regs.reelection_interval <= cfg.data[stp_pkg::TIMER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stp_engine.sv =====
// ============================================================================
// stp_engine - root election state and per-beat update
// Holds root/path/parent, per-port known/blocked/unused bits and the two
// timers; computes the result of the beat in the input register.
// ============================================================================
`default_nettype none

module stp_engine #(
  parameter int MAX_PORTS = stp_pkg::MAX_PORTS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  stp_pkg::item_t     item,
  input  stp_pkg::cfg_t      regs,
  input  stp_pkg::own_load_t own_load,
  output stp_pkg::result_t   res
);

  localparam int AW = stp_pkg::ADDR_W;
  localparam int CW = stp_pkg::CNT_W;
  localparam int TW = stp_pkg::TIMER_W;
  localparam int MW = stp_pkg::MASK_W;

  logic [AW-1:0]        root, path, parent;
  logic [AW-1:0]        root_next, path_next, parent_next;
  logic [MAX_PORTS-1:0] known, blocked, unused;
  logic [MAX_PORTS-1:0] known_next, blocked_next, unused_next;
  logic [CW-1:0]        unused_cnt, unused_cnt_next;
  logic [TW-1:0]        hello_timer, reelect_timer;
  logic [TW-1:0]        hello_timer_next, reelect_timer_next;

  logic [CW-1:0]        n_ports;
  logic [MAX_PORTS-1:0] all_mask, port_hit, send;
  logic                 port_ok;
  logic [AW:0]          plus, path_ext;
  logic [TW-1:0]        hello_inc, reelect_inc;
  logic                 changed;
  logic [MAX_PORTS+MW-1:0] send_ext, blocked_ext;

  always_comb begin
    if (32'(regs.port_count) > MAX_PORTS) n_ports = CW'(MAX_PORTS);
    else                                  n_ports = regs.port_count;
    for (int i = 0; i < MAX_PORTS; i++) begin
      all_mask[i] = (i < int'(n_ports));
      port_hit[i] = (int'(item.in_port) == i);
    end
  end

  assign port_ok     = int'(item.in_port) < int'(n_ports);
  assign plus        = {1'b0, item.hello_path} + (AW+1)'(1);
  assign path_ext    = {1'b0, path};
  assign hello_inc   = (hello_timer == '1) ? hello_timer : hello_timer + TW'(1);
  assign reelect_inc = (reelect_timer == '1) ? reelect_timer : reelect_timer + TW'(1);

  always_comb begin
    root_next          = root;
    path_next          = path;
    parent_next        = parent;
    known_next         = known;
    blocked_next       = blocked;
    unused_next        = unused;
    unused_cnt_next    = unused_cnt;
    hello_timer_next   = hello_timer;
    reelect_timer_next = reelect_timer;
    send               = '0;
    changed            = 1'b0;

    if (item.action == stp_pkg::ACT_TICK) begin
      hello_timer_next   = hello_inc;
      reelect_timer_next = reelect_inc;
      if (root == regs.own_address) begin
        if (hello_inc >= regs.hello_interval) begin
          send             = all_mask;
          hello_timer_next = '0;
        end
      end else if (reelect_inc >= regs.reelection_interval) begin
        // claim root
        root_next          = regs.own_address;
        path_next          = '0;
        parent_next        = regs.own_address;
        send               = all_mask;
        blocked_next       = blocked & ~all_mask;
        reelect_timer_next = '0;
      end
    end else if (port_ok) begin
      reelect_timer_next = '0;
      if (item.hello_root == root && plus == path_ext && item.hello_sender == parent) begin
        // parent hello: relay on every other port
        send = all_mask & ~port_hit;
      end else begin
        if (!(|(known & port_hit))) begin
          // an all-ones sender still reads as unknown
          if (item.hello_sender != stp_pkg::UNKNOWN_ADDR)
            known_next = known | port_hit;
          blocked_next = blocked_next & ~port_hit;
        end
        if (item.hello_root < root) begin
          root_next   = item.hello_root;
          path_next   = plus[AW] ? '1 : plus[AW-1:0];
          parent_next = item.hello_sender;
          changed     = 1'b1;
        end else if (item.hello_root == root && plus < path_ext) begin
          path_next   = plus[AW] ? '1 : plus[AW-1:0];
          parent_next = item.hello_sender;
          changed     = 1'b1;
        end else if (item.hello_root == root && plus == path_ext &&
                     item.hello_sender < parent) begin
          parent_next = item.hello_sender;
          changed     = 1'b1;
        end
        if (changed) begin
          send            = all_mask;
          unused_cnt_next = '0;
          unused_next     = '0;
        end
        // blocking decision sees the updated tree position
        if (item.hello_sender == parent_next) begin
          blocked_next = blocked_next & ~port_hit;
        end else if (item.hello_root == root_next &&
                     {1'b0, item.hello_path} == ({1'b0, path_next} + (AW+1)'(1))) begin
          blocked_next = blocked_next & ~port_hit;
        end else if (!(|(unused_next & port_hit))) begin
          unused_next     = unused_next | port_hit;
          unused_cnt_next = unused_cnt_next + CW'(1);
        end
      end
    end
  end

  // ports beyond storage: never sent on, always read as blocked
  assign send_ext    = {{MW{1'b0}}, send};
  assign blocked_ext = {{MW{1'b1}}, blocked_next};

  always_comb begin
    res.send_mask    = send_ext[MW-1:0];
    res.root_now     = root_next;
    res.path_now     = path_next;
    res.parent_now   = parent_next;
    res.blocked_mask = blocked_ext[MW-1:0];
    res.converged    = (n_ports != '0) && (unused_cnt_next == n_ports - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root          <= stp_pkg::OWN_ADDRESS_RST;
      path          <= '0;
      parent        <= stp_pkg::OWN_ADDRESS_RST;
      known         <= '0;
      blocked       <= '1;
      unused        <= '0;
      unused_cnt    <= '0;
      hello_timer   <= '0;
      reelect_timer <= '0;
    end else if (own_load.load) begin
      root   <= own_load.addr;
      path   <= '0;
      parent <= own_load.addr;
    end else if (fire) begin
      root          <= root_next;
      path          <= path_next;
      parent        <= parent_next;
      known         <= known_next;
      blocked       <= blocked_next;
      unused        <= unused_next;
      unused_cnt    <= unused_cnt_next;
      hello_timer   <= hello_timer_next;
      reelect_timer <= reelect_timer_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spanning_tree_port_state_core.sv =====
// ============================================================================
// spanning_tree_port_state_core - spanning-tree root election, one node
// Input register, single-pass update engine and result register.
// ============================================================================
// Usage:
//   item   : one beat is a tick (action 0) or a received hello (action 1)
//            with port, root, path and sender.
//   result : exactly one beat per item: ports to send our hello on, the
//            root/path/parent after the item, blocked ports, converged flag.
//   cfg    : register writes by index (own address, port count, hello and
//            re-election intervals); always ready. Write only while idle.
// An item beat passes from the input register to the result register, and
// result valid rises there. Throughput is one item per cycle unless the
// result stalls: the whole update is one compare/mask pass on the beat in
// the input register, and state is written as the beat moves to the result
// register, so the next beat sees it directly.
// When result.ready is low the result register holds, the input register
// fills, and item.ready drops; nothing is dropped or repeated.
// Reset clears both registers, sets root and parent to address zero, path
// zero, all ports blocked, no neighbors known and both timers to zero.
// ============================================================================
`default_nettype none

module spanning_tree_port_state_core #(
  parameter int MAX_PORTS = stp_pkg::MAX_PORTS_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  stp_item_if.sink     item,
  stp_result_if.source result,
  stp_cfg_if.sink      cfg
);

  stp_pkg::cfg_t      regs;
  stp_pkg::own_load_t own_load;
  stp_pkg::item_t     s0_item;
  stp_pkg::result_t   eng_res, res;
  logic               s0_valid, res_valid;
  logic               adv, fire;

  stp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .regs     (regs),
    .own_load (own_load)
  );

  stp_engine #(.MAX_PORTS(MAX_PORTS)) u_engine (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (s0_item),
    .regs     (regs),
    .own_load (own_load),
    .res      (eng_res)
  );

  assign adv        = !res_valid || result.ready;
  assign fire       = s0_valid && adv;
  assign item.ready = !s0_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (item.ready) s0_valid  <= item.valid;
      if (adv)        res_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s0_item.action       <= stp_pkg::action_t'(item.action);
      s0_item.in_port      <= item.in_port;
      s0_item.hello_root   <= item.hello_root;
      s0_item.hello_path   <= item.hello_path;
      s0_item.hello_sender <= item.hello_sender;
    end
    if (fire) res <= eng_res;
  end

  assign result.valid        = res_valid;
  assign result.send_mask    = res.send_mask;
  assign result.root_now     = res.root_now;
  assign result.path_now     = res.path_now;
  assign result.parent_now   = res.parent_now;
  assign result.blocked_mask = res.blocked_mask;
  assign result.converged    = res.converged;

endmodule

`default_nettype wire

// ===== hw/rtl/stp_checker.sv =====
// ============================================================================
// stp_checker - port-level checks for the spanning-tree core
// Result channel stability, reset behavior and tree position consistency.
// ============================================================================
`default_nettype none

module stp_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       res_valid,
  input wire logic                       res_ready,
  input wire logic [stp_pkg::MASK_W-1:0] send_mask,
  input wire logic [stp_pkg::ADDR_W-1:0] root_now,
  input wire logic [stp_pkg::ADDR_W-1:0] path_now,
  input wire logic [stp_pkg::ADDR_W-1:0] parent_now
);

  // a stalled result beat stays
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(root_now) && $stable(path_now) &&
                                $stable(parent_now) && $stable(send_mask))
    else $error("result payload changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // zero path only when we are root, so parent is ourselves
  a_root_parent: assert property (@(posedge clk) disable iff (rst)
    res_valid && path_now == '0 |-> root_now == parent_now)
    else $error("zero path with foreign parent");

endmodule

bind spanning_tree_port_state_core stp_checker u_stp_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .send_mask  (result.send_mask),
  .root_now   (result.root_now),
  .path_now   (result.path_now),
  .parent_now (result.parent_now)
);

`default_nettype wire
